[src/stai_pkg.sv]
// Package for the sample time alignment block: types, codes and constants.
// No dependencies; used by every module in src.
package stai_pkg;

    localparam int TIME_W = 48;
    localparam int STAT_W = 8;
    localparam int VAL_W  = 41;
    localparam int LAT_W  = 40;
    localparam int WBITS  = 24;
    localparam int NVAL   = 6;

    // input word modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_SYNC = 1'b1;

    // result codes
    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NEWER    = 2'd1;
    localparam logic [1:0] RES_SHORT    = 2'd2;
    localparam logic [1:0] RES_GAP      = 2'd3;

    localparam logic [47:0] MAX_GAP_RESET = 48'd2000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    // divider control between sequencer and divider
    typedef struct packed {
        logic             start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WBITS:0]   weight;
    } div_rsp_t;

endpackage

[src/stai_div.sv]
// Restoring divider: weight = floor(n * 2^24 / d), one quotient bit a cycle.
// Gives 2^24 when n >= d and 0 when d = 0. Depends on stai_pkg.
module stai_div
    import stai_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [TIME_W:0]   rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [WBITS:0]    q_reg, q_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   shl;

    assign shl = {rem_reg[TIME_W-1:0], 1'b0};

    // one restoring step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            den_next = req.den;
            rem_next = {1'b0, req.num};
            cnt_next = 5'd0;
            if (req.den == '0)
            begin
                q_next = '0;
                done_next = 1'b1;
            end
            else if (req.num >= req.den)
            begin
                q_next = (WBITS+1)'(1) << WBITS;
                done_next = 1'b1;
            end
            else
            begin
                q_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (shl >= {1'b0, den_reg})
            begin
                rem_next = shl - {1'b0, den_reg};
                q_next   = {q_reg[WBITS-1:0], 1'b1};
            end
            else
            begin
                rem_next = shl;
                q_next   = {q_reg[WBITS-1:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(WBITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.weight = q_reg;

endmodule

[src/stai_interp.sv]
// Shared interpolation unit: one value per cycle, a + round((b - a) * w / 2^24).
// The 42x25 product is split into two registered partial products.
// Depends on stai_pkg.
module stai_interp
    import stai_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    input  logic [WBITS:0]     weight,
    output logic               out_valid,
    output logic signed [VAL_W-1:0] result
);

    localparam int MW  = VAL_W + 1;
    localparam int PHW = MW + 1;
    localparam int PLW = 2 * WBITS + 1;

    logic              neg;
    logic [MW-1:0]     mag;
    logic signed [MW-1:0] diff;

    // stage 1 registers: partial products
    logic [PHW-1:0]          ph_reg;
    logic [PLW-1:0]          pl_reg;
    logic                    neg_reg;
    logic signed [VAL_W-1:0] a_reg;
    logic                    v1_reg;

    // stage 2 combine
    logic [MW-1:0]    q;
    logic [WBITS-1:0] r;
    logic [MW-1:0]    qr;

    assign diff = MW'(b) - MW'(a);
    assign neg  = diff[MW-1];
    assign mag  = neg ? MW'(-diff) : diff;

    always_ff @(posedge clk)
    begin
        ph_reg  <= PHW'(mag[MW-1:WBITS]) * PHW'(weight);
        pl_reg  <= PLW'(mag[WBITS-1:0]) * PLW'(weight);
        neg_reg <= neg;
        a_reg   <= a;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_comb
    begin
        q = MW'(ph_reg) + MW'(pl_reg >> WBITS);
        r = pl_reg[WBITS-1:0];
        qr = q;
        if (neg_reg)
        begin
            if (r > WBITS'(1 << (WBITS-1)))
                qr = q + MW'(1);
        end
        else if (r >= WBITS'(1 << (WBITS-1)))
            qr = q + MW'(1);
    end

    always_ff @(posedge clk)
    begin
        result    <= neg_reg ? VAL_W'(a_reg - $signed(qr[VAL_W-1:0]))
                             : VAL_W'(a_reg + $signed(qr[VAL_W-1:0]));
    end

endmodule

[src/sample_time_align_interp_top.sv]
// Sample time alignment with linear interpolation: top level.
// Usage:
//   in_valid/in_ready take one word: mode 0 pushes a sample into a queue of
//   QUEUE_DEPTH entries (oldest dropped when full), mode 1 is a sync request.
//   out_valid/out_ready deliver one result word per sync request, none for a
//   push. cfg_valid/cfg_ready write max_gap; write it only while idle.
// Sequence:
//   A push writes its word and returns to idle. A request reads the two
//   front entries through the single registered read port and checks
//   them; each front entry dropped as too old costs another read and check.
//   A failed request shows its result without a read (under two samples)
//   or after the check (front newer, gap too large). An aligned request
//   then runs the shared restoring divider, which skips its steps when the
//   request time equals the second entry's time, and the shared interpolation
//   multiplier before its result shows. One word at a time.
// Reset: clears queue pointers and count, max_gap = 2000000; data kept.
// Stall: a result waits in the output register while out_ready is low; the
//   next word is taken in the cycle after the result has been taken.
// Depends on stai_pkg, stai_div, stai_interp.
module sample_time_align_interp_top
    import stai_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TIME_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [TIME_W-1:0]        stamp,
    input  logic [STAT_W-1:0]        fix_status,
    input  logic signed [VAL_W-1:0]  longitude,
    input  logic signed [LAT_W-1:0]  latitude,
    input  logic signed [VAL_W-1:0]  altitude,
    input  logic signed [VAL_W-1:0]  east,
    input  logic signed [VAL_W-1:0]  north,
    input  logic signed [VAL_W-1:0]  up,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               result_code,
    output logic [TIME_W-1:0]        out_time,
    output logic [STAT_W-1:0]        out_status,
    output logic signed [VAL_W-1:0]  out_longitude,
    output logic signed [LAT_W-1:0]  out_latitude,
    output logic signed [VAL_W-1:0]  out_altitude,
    output logic signed [VAL_W-1:0]  out_east,
    output logic signed [VAL_W-1:0]  out_north,
    output logic signed [VAL_W-1:0]  out_up
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TIME_W + STAT_W + NVAL * VAL_W;

    // queue storage, one entry = time, status, six values (latitude extended)
    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TIME_W-1:0] max_gap_reg;
    logic [TIME_W-1:0] req_reg;
    logic              mode_reg;
    logic [EW-1:0]     in_word_reg;
    logic [EW-1:0]     e0_reg, e0_next;
    logic [EW-1:0]     e1_reg, e1_next;
    logic [1:0]        phase_reg, phase_next;   // read step: front, second, capture
    logic [2:0]        vidx_reg, vidx_next;
    logic [2:0]        vsel;
    logic [WBITS:0]    w_reg, w_next;
    logic              out_valid_reg;
    logic [1:0]        code_reg, code_next;
    logic [STAT_W-1:0] ostat_reg;
    logic signed [VAL_W-1:0] oval_reg [NVAL];

    div_req_t dreq;
    div_rsp_t drsp;
    logic     mul_start;
    logic     mul_done;
    logic signed [VAL_W-1:0] mul_res;
    logic signed [VAL_W-1:0] va, vb;
    logic [2:0] widx_reg;
    logic       widx_en;

    logic [TIME_W-1:0] t0, t1;
    logic              gap_bad;
    logic [AW-1:0] slot0, slot1, slot_tail;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] r;
        begin
            r = v;
            if (r >= (AW+1)'(QUEUE_DEPTH))
                r = r - (AW+1)'(QUEUE_DEPTH);
            wrap = r[AW-1:0];
        end
    endfunction

    assign slot0 = head_reg;
    assign slot1 = wrap({1'b0, head_reg} + (AW+1)'(1));
    assign t0 = e0_reg[EW-1 -: TIME_W];
    assign t1 = e1_reg[EW-1 -: TIME_W];
    assign gap_bad = (req_reg - t0 > max_gap_reg) || (t1 - req_reg > max_gap_reg);

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_gap_reg <= MAX_GAP_RESET;
        else if (cfg_valid && cfg_ready)
            max_gap_reg <= cfg_data;
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg     <= stamp;
            mode_reg    <= mode;
            in_word_reg <= {stamp, fix_status, longitude, VAL_W'(latitude),
                            altitude, east, north, up};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && in_ready) state_next = ST_READ;
            ST_READ:
            begin
                if (mode_reg == MODE_PUSH)
                    state_next = ST_IDLE;
                else if (count_reg < CW'(2))
                    state_next = ST_OUT;
                else if (phase_reg == 2'd2)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (t0 > req_reg)
                    state_next = ST_OUT;
                else if (t1 < req_reg)
                    state_next = ST_READ;
                else if (gap_bad)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:   if (drsp.done) state_next = ST_MUL;
            ST_MUL:   if (mul_done && widx_reg == 3'(NVAL - 1)) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        phase_next = phase_reg;
        vidx_next  = vidx_reg;
        w_next     = w_reg;
        code_next  = code_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = in_word_reg;
        rd_addr    = slot0;
        dreq.start = 1'b0;
        dreq.num   = req_reg - t0;
        dreq.den   = t1 - t0;
        mul_start  = 1'b0;
        slot_tail  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                phase_next = 2'd0;
                if (in_valid && in_ready)
                    code_next = RES_OK;
            end
            ST_READ:
            begin
                if (mode_reg == MODE_PUSH)
                begin
                    wr_en = 1'b1;
                    if (count_reg >= CW'(QUEUE_DEPTH))
                    begin
                        head_next = slot1;
                        wr_addr   = head_reg;
                    end
                    else
                    begin
                        slot_tail  = wrap({1'b0, head_reg} + (AW+1)'(count_reg));
                        wr_addr    = slot_tail;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (count_reg < CW'(2))
                    code_next = RES_SHORT;
                else
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            rd_addr    = slot0;
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            rd_addr    = slot1;
                            e0_next    = rd_data_reg;
                            phase_next = 2'd2;
                        end
                        default:
                        begin
                            e1_next    = rd_data_reg;
                            phase_next = 2'd0;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (t0 > req_reg)
                    code_next = RES_NEWER;
                else if (t1 < req_reg)
                begin
                    head_next  = slot1;
                    count_next = count_reg - CW'(1);
                end
                else if (gap_bad)
                begin
                    head_next  = slot1;
                    count_next = count_reg - CW'(1);
                    code_next  = RES_GAP;
                end
                else
                begin
                    dreq.start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    w_next    = drsp.weight;
                    vidx_next = 3'd0;
                end
            end
            ST_MUL:
            begin
                if (vidx_reg < 3'(NVAL))
                begin
                    mul_start = 1'b1;
                    vidx_next = vidx_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg   <= e0_next;
        e1_reg   <= e1_next;
        vidx_reg <= vidx_next;
        w_reg    <= w_next;
        code_reg <= code_next;
    end

    // shared divider
    stai_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // value select for the shared multiplier
    assign vsel = (vidx_reg < 3'(NVAL)) ? vidx_reg : 3'd0;
    always_comb
    begin
        va = e0_reg[(NVAL-1-vsel)*VAL_W +: VAL_W];
        vb = e1_reg[(NVAL-1-vsel)*VAL_W +: VAL_W];
    end

    stai_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_start),
        .a         (va),
        .b         (vb),
        .weight    (w_reg),
        .out_valid (mul_done),
        .result    (mul_res)
    );

    // write-back index follows the multiplier latency
    assign widx_en = mul_done;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            widx_reg <= '0;
        else if (state_reg == ST_DIV)
            widx_reg <= '0;
        else if (widx_en)
            widx_reg <= widx_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (widx_en)
            oval_reg[widx_reg] <= mul_res;
        if (state_reg == ST_CHECK)
            ostat_reg <= e1_reg[NVAL*VAL_W +: STAT_W];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    logic ok;
    assign ok = (code_reg == RES_OK);
    assign out_valid     = out_valid_reg;
    assign result_code   = code_reg;
    assign out_time      = req_reg;
    assign out_status    = ok ? ostat_reg : '0;
    assign out_longitude = ok ? oval_reg[0] : '0;
    assign out_latitude  = ok ? LAT_W'(oval_reg[1]) : '0;
    assign out_altitude  = ok ? oval_reg[2] : '0;
    assign out_east      = ok ? oval_reg[3] : '0;
    assign out_north     = ok ? oval_reg[4] : '0;
    assign out_up        = ok ? oval_reg[5] : '0;

endmodule

[src/stai_checker.sv]
// Port-level checker for the alignment block, bound to the top level.
// Depends on stai_pkg.
module stai_checker
    import stai_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] result_code,
    input logic [47:0] out_time,
    input logic [7:0] out_status
);

    // a held result stays valid and keeps its time
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_time);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    // no new word while a result waits
    property p_no_accept;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready;
    endproperty
    a_no_accept: assert property (p_no_accept) else $error("input taken with result pending");

    // accepted word drops ready next cycle
    property p_busy;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready stayed high after accept");

    // failed results carry zero status
    property p_fail_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && result_code != RES_OK |-> out_status == '0;
    endproperty
    a_fail_zero: assert property (p_fail_zero) else $error("failed result has status");

endmodule

bind sample_time_align_interp_top stai_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_code (result_code),
    .out_time    (out_time),
    .out_status  (out_status)
);
